// ===== hw/rtl/oid_pkg.sv =====
// Package for the ordered insert deque: request codes, beat payload types and
// the command/status structs passed between controller and datapath.
// No dependencies.
`default_nettype none

package oid_pkg;

  localparam int unsigned OID_DEPTH = 16;

  // request codes carried in req_type
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_INSERT     = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] item_value;
  } oid_in_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic [4:0]         entry_count;
    logic               dropped;
  } oid_out_t;

  // logical index driven onto the read port
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_NEXT,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_FRONT,
    WR_BACK,
    WR_IDX_VAL,
    WR_IDX_RD
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef enum logic [1:0] {
    HEAD_HOLD,
    HEAD_INC,
    HEAD_DEC
  } head_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_e;

  typedef struct packed {
    logic     load;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    cnt_op_e  cnt_op;
    head_op_e head_op;
    idx_op_e  idx_op;
    logic     cap_prev;
    logic     cap_pos;
    logic     cap_front;
    logic     set_drop;
    logic     emit;
  } oid_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       full;
    logic       empty;
    logic       le_rd;     // value <= read data
    logic       ge_rd;     // value >= read data
    logic       fit;       // prev <= value <= read data
    logic       at_last;
    logic       at_pos;
  } oid_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oid_datapath.sv =====
// Datapath of the ordered insert deque: circular entry memory, head, count and
// scan index registers, comparators and the result register. Uses oid_pkg.
`default_nettype none

module oid_datapath
  import oid_pkg::*;
#(
  parameter int unsigned DEPTH = OID_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  oid_in_t     req_i,
  input  oid_cmd_t    cmd_i,
  output oid_status_t sts_o,
  output oid_out_t    rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PHYS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      pos_q;
  logic [2:0]         req_q;
  logic signed [31:0] val_q;
  logic signed [31:0] rdata_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] front_q;
  logic               drop_q;
  oid_out_t           rsp_q;

  logic               empty, full;
  logic [AW-1:0]      last_log, count_log, rd_log;
  logic [AW-1:0]      head_inc, head_dec;
  logic [AW-1:0]      rd_phys, wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;
  logic [31:0]        cnt_ext;

  // logical position to physical slot, head + l modulo DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, l};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign empty     = (count_q == '0);
  assign full      = (count_q == FULL_CNT);
  assign count_log = AW'(count_q);
  assign last_log  = empty ? '0 : AW'(count_q - CW'(1));
  assign head_inc  = (head_q == LAST_PHYS) ? '0 : head_q + AW'(1);
  assign head_dec  = (head_q == '0) ? LAST_PHYS : head_q - AW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST: rd_log = '0;
      RD_LAST:  rd_log = last_log;
      RD_NEXT:  rd_log = idx_q + AW'(1);
      RD_PREV:  rd_log = idx_q - AW'(1);
      default:  rd_log = '0;
    endcase
  end

  assign rd_phys = phys(head_q, rd_log);

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = phys(head_q, idx_q);
    wr_data = val_q;
    unique case (cmd_i.wr_sel)
      WR_NONE:    wr_en = 1'b0;
      WR_FRONT:   wr_addr = head_dec;
      WR_BACK:    wr_addr = phys(head_q, count_log);
      WR_IDX_VAL: wr_data = val_q;
      WR_IDX_RD:  wr_data = rdata_q;
      default:    wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_phys];
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CW'(1);
      CNT_DEC:  count_d = count_q - CW'(1);
      CNT_CLR:  count_d = '0;
      default:  count_d = count_q;
    endcase
    unique case (cmd_i.head_op)
      HEAD_HOLD: head_d = head_q;
      HEAD_INC:  head_d = head_inc;
      HEAD_DEC:  head_d = head_dec;
      default:   head_d = head_q;
    endcase
    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_q + AW'(1);
      IDX_DEC:   idx_d = idx_q - AW'(1);
      IDX_COUNT: idx_d = count_log;
      default:   idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign cnt_ext = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i.req_type;
      val_q  <= req_i.item_value;
      drop_q <= 1'b0;
    end else if (cmd_i.set_drop) begin
      drop_q <= 1'b1;
    end
    if (cmd_i.cap_prev) begin
      prev_q <= rdata_q;
    end
    if (cmd_i.cap_pos) begin
      pos_q <= idx_q;
    end
    if (cmd_i.cap_front) begin
      front_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      rsp_q.front_value <= empty ? '0 : front_q;
      rsp_q.back_value  <= empty ? '0 : rdata_q;
      rsp_q.is_empty    <= empty;
      rsp_q.entry_count <= cnt_ext[4:0];
      rsp_q.dropped     <= drop_q;
    end
  end

  assign rsp_o = rsp_q;

  assign sts_o.req     = req_q;
  assign sts_o.full    = full;
  assign sts_o.empty   = empty;
  assign sts_o.le_rd   = (val_q <= rdata_q);
  assign sts_o.ge_rd   = (val_q >= rdata_q);
  assign sts_o.fit     = (prev_q <= val_q) && (val_q <= rdata_q);
  assign sts_o.at_last = (idx_q == last_log);
  assign sts_o.at_pos  = (idx_q == pos_q);

endmodule

`default_nettype wire

// ===== hw/rtl/oid_ctrl.sv =====
// Controller of the ordered insert deque: sequences each request over the
// datapath and raises busy and the result strobe. Uses oid_pkg.
`default_nettype none

module oid_ctrl
  import oid_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  output logic        done_o,
  input  oid_status_t sts_i,
  output oid_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_F,
    S_INS_B,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_RD_FRONT,
    S_RD_BACK,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    done_d  = 1'b0;

    cmd_o           = '0;
    cmd_o.rd_sel    = RD_FIRST;
    cmd_o.wr_sel    = WR_NONE;
    cmd_o.cnt_op    = CNT_HOLD;
    cmd_o.head_op   = HEAD_HOLD;
    cmd_o.idx_op    = IDX_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (start && !busy_q) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RD_FRONT;
        unique case (sts_i.req)
          REQ_PUSH_FRONT: begin
            if (sts_i.full) begin
              cmd_o.set_drop = 1'b1;
            end else begin
              cmd_o.wr_sel  = WR_FRONT;
              cmd_o.head_op = HEAD_DEC;
              cmd_o.cnt_op  = CNT_INC;
            end
          end
          REQ_PUSH_BACK: begin
            if (sts_i.full) begin
              cmd_o.set_drop = 1'b1;
            end else begin
              cmd_o.wr_sel = WR_BACK;
              cmd_o.cnt_op = CNT_INC;
            end
          end
          REQ_POP_FRONT: begin
            if (!sts_i.empty) begin
              cmd_o.head_op = HEAD_INC;
              cmd_o.cnt_op  = CNT_DEC;
            end
          end
          REQ_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_drop = 1'b1;
            end else if (sts_i.empty) begin
              cmd_o.wr_sel = WR_BACK;
              cmd_o.cnt_op = CNT_INC;
            end else begin
              cmd_o.rd_sel = RD_FIRST;
              state_d      = S_INS_F;
            end
          end
          REQ_CLEAR: begin
            cmd_o.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end

      // read data holds the front entry
      S_INS_F: begin
        cmd_o.cap_prev = 1'b1;
        cmd_o.idx_op   = IDX_ZERO;
        if (sts_i.le_rd) begin
          cmd_o.wr_sel  = WR_FRONT;
          cmd_o.head_op = HEAD_DEC;
          cmd_o.cnt_op  = CNT_INC;
          state_d       = S_RD_FRONT;
        end else begin
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_INS_B;
        end
      end

      // read data holds the back entry
      S_INS_B: begin
        if (sts_i.ge_rd) begin
          cmd_o.wr_sel = WR_BACK;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_RD_FRONT;
        end else begin
          cmd_o.rd_sel = RD_NEXT;
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SCAN;
        end
      end

      // read data holds entry idx, prev holds entry idx-1
      S_SCAN: begin
        if (sts_i.fit) begin
          cmd_o.cap_pos = 1'b1;
          cmd_o.idx_op  = IDX_COUNT;
          state_d       = S_SH_RD;
        end else if (sts_i.at_last) begin
          cmd_o.set_drop = 1'b1;
          state_d        = S_RD_FRONT;
        end else begin
          cmd_o.cap_prev = 1'b1;
          cmd_o.rd_sel   = RD_NEXT;
          cmd_o.idx_op   = IDX_INC;
        end
      end

      // move entries up one slot from the tail down to the insert point
      S_SH_RD: begin
        if (sts_i.at_pos) begin
          cmd_o.wr_sel = WR_IDX_VAL;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_RD_FRONT;
        end else begin
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cmd_o.wr_sel = WR_IDX_RD;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_SH_RD;
      end

      S_RD_FRONT: begin
        cmd_o.rd_sel = RD_FIRST;
        state_d      = S_RD_BACK;
      end

      S_RD_BACK: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_sel    = RD_LAST;
        state_d         = S_OUT;
      end

      S_OUT: begin
        cmd_o.emit = 1'b1;
        done_d     = 1'b1;
        busy_d     = 1'b0;
        state_d    = S_IDLE;
      end

      default: begin
        busy_d  = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_insert_deque.sv =====
// Top level of the ordered insert deque: joins controller and datapath.
// Depends on oid_pkg, oid_ctrl and oid_datapath.
`default_nettype none

// A bounded list of up to DEPTH signed 32-bit values held in a circular
// buffer with one read and one write port. A request is taken when start is
// high and busy is low; its result beat is loaded onto rsp_o as done_o goes
// high for exactly one cycle, and must be taken then, as there is no back-pressure.
// Push front, push back, pop, clear, unused codes and an ordered insert
// into an empty or full list act in the execute state alone. An ordered
// insert first compares the value with the front entry, then with the back
// entry; else it scans the entries past the front for the first pair the
// value fits between and moves the entries behind that point one slot
// towards the back, each read and then written. One that finds no fitting
// pair is dropped. The entry memory offers one read and one write per
// cycle, and the front and back values are read back from it after every
// request. A new request may be taken in the cycle that carries done_o. No
// clearing pass follows reset.

module ordered_insert_deque
  import oid_pkg::*;
#(
  parameter int unsigned DEPTH = OID_DEPTH
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      start,
  output logic     busy,
  input  oid_in_t  req_i,
  output logic     done_o,
  output oid_out_t rsp_o
);

  oid_cmd_t    cmd;
  oid_status_t sts;

  oid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oid_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire
